### rtl/gcmi_pkg.sv
package gcmi_pkg;

  localparam int KNOT_SLOTS = 8;
  localparam int KIDX_W     = 3;
  localparam int KNOT_W     = 40;
  localparam int POS_W      = 16;
  localparam int CH_W       = 8;
  localparam int CH_COUNT   = 3;
  localparam int BIT_W      = 3;
  localparam int PROD_W     = 26;
  localparam int NUM_W      = 27;
  localparam int REM_W      = 24;
  localparam int COLOR_W    = 32;

  localparam logic [CH_W-1:0]   ALPHA_OPAQUE   = 8'hFF;
  localparam logic [CH_W-1:0]   CH_MAX         = 8'hFF;
  localparam logic [KNOT_W-1:0] KNOT_FIRST_RST = 40'h00_0000_0000;
  localparam logic [KNOT_W-1:0] KNOT_REST_RST  = 40'hFF_FFFF_FFFF;
  localparam logic [BIT_W-1:0]  BIT_TOP        = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic             search;
    logic             last;
    logic             mul;
    logic             div_init;
    logic             div_step;
    logic [BIT_W-1:0] bit_idx;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
  } dp_status_t;

  function automatic logic [POS_W-1:0] knot_pos(logic [KNOT_W-1:0] k);
    return k[KNOT_W-1 -: POS_W];
  endfunction

  function automatic logic [CH_W-1:0] knot_chan(logic [KNOT_W-1:0] k, int unsigned c);
    return k[CH_W*(CH_COUNT-1-c) +: CH_W];
  endfunction

endpackage

### rtl/gcmi_knots.sv
module gcmi_knots (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gcmi_pkg::KIDX_W-1:0]    cfg_index,
  input  logic [gcmi_pkg::KNOT_W-1:0]    cfg_data,
  input  logic [gcmi_pkg::KIDX_W-1:0]    rd_addr,
  output logic [gcmi_pkg::KNOT_W-1:0]    rd_data
);
  import gcmi_pkg::*;

  logic [KNOT_W-1:0] knot [KNOT_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KNOT_SLOTS; i++) begin
        knot[i] <= (i == 0) ? KNOT_FIRST_RST : KNOT_REST_RST;
      end
    end else if (cfg_write) begin
      knot[cfg_index] <= cfg_data;
    end
  end

  assign rd_data = knot[rd_addr];

endmodule

### rtl/gcmi_ctrl.sv
module gcmi_ctrl #(
  parameter int KNOT_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gcmi_pkg::KIDX_W-1:0]  rd_addr,
  output gcmi_pkg::ctrl_cmd_t          cmd,
  input  gcmi_pkg::dp_status_t         status
);
  import gcmi_pkg::*;

  localparam logic [KIDX_W-1:0] LAST_IDX = KIDX_W'(KNOT_COUNT - 1);

  state_t            state, state_next;
  logic [KIDX_W-1:0] knot_idx;
  logic [BIT_W-1:0]  bit_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_SEARCH;
      S_SEARCH:   if (status.hit || knot_idx == LAST_IDX) state_next = S_MUL;
      S_MUL:      state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (bit_idx == '0) state_next = S_DONE;
      S_DONE:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    rd_addr      = '0;
    cmd.bit_idx  = bit_idx;
    cmd.last     = (knot_idx == LAST_IDX);
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SEARCH: begin
        rd_addr    = knot_idx;
        cmd.search = 1'b1;
      end
      S_MUL:      cmd.mul = 1'b1;
      S_DIV_INIT: cmd.div_init = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_DONE:     cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      knot_idx  <= '0;
      bit_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        knot_idx <= KIDX_W'(1);
      end else if (cmd.search) begin
        knot_idx <= knot_idx + KIDX_W'(1);
      end
      if (cmd.div_init) begin
        bit_idx <= BIT_TOP;
      end else if (cmd.div_step) begin
        bit_idx <= bit_idx - BIT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/gcmi_dp.sv
module gcmi_dp (
  input  logic                         clk,
  input  logic [7:0]                   palette_index,
  input  logic [gcmi_pkg::KNOT_W-1:0]  rd_data,
  input  gcmi_pkg::ctrl_cmd_t          cmd,
  output gcmi_pkg::dp_status_t         status,
  output logic [gcmi_pkg::COLOR_W-1:0] color_word
);
  import gcmi_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [KNOT_W-1:0] knot_a, knot_a0, knot_b;
  logic [POS_W-1:0]  span;
  logic              span_pos;
  logic signed [NUM_W-1:0] num [CH_COUNT];
  logic [REM_W-1:0]  rem [CH_COUNT];
  logic [CH_W-1:0]   quo [CH_COUNT];
  logic [CH_COUNT-1:0] neg, sat;

  logic signed [POS_W:0] span_s, d_s;
  logic signed [CH_W:0]  ca_s [CH_COUNT];
  logic signed [CH_W:0]  diff_s [CH_COUNT];
  logic signed [PROD_W-1:0] prod_base [CH_COUNT];
  logic signed [PROD_W-1:0] prod_step [CH_COUNT];
  logic signed [NUM_W-1:0]  num_next [CH_COUNT];
  logic [REM_W-1:0]  span_top;
  logic [REM_W-1:0]  trial;
  logic [CH_W-1:0]   chan [CH_COUNT];

  assign status.hit = (pos >= knot_pos(knot_a)) && (pos <= knot_pos(rd_data));

  assign span_s   = $signed({1'b0, knot_pos(knot_b)}) - $signed({1'b0, knot_pos(knot_a)});
  assign d_s      = $signed({1'b0, pos}) - $signed({1'b0, knot_pos(knot_a)});
  assign span_top = {span, 8'd0};
  assign trial    = REM_W'({8'd0, span} << cmd.bit_idx);

  always_comb begin
    for (int c = 0; c < CH_COUNT; c++) begin
      ca_s[c]      = $signed({1'b0, knot_chan(knot_a, c)});
      diff_s[c]    = $signed({1'b0, knot_chan(knot_b, c)}) - ca_s[c];
      prod_base[c] = PROD_W'(ca_s[c]) * PROD_W'(span_s);
      prod_step[c] = PROD_W'(d_s) * PROD_W'(diff_s[c]);
      num_next[c]  = NUM_W'(prod_base[c]) + NUM_W'(prod_step[c]);
      if (!span_pos) begin
        chan[c] = knot_chan(knot_a, c);
      end else if (neg[c]) begin
        chan[c] = '0;
      end else if (sat[c]) begin
        chan[c] = CH_MAX;
      end else begin
        chan[c] = quo[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos     <= {palette_index, palette_index};
      knot_a  <= rd_data;
      knot_a0 <= rd_data;
    end
    if (cmd.search) begin
      if (status.hit) begin
        knot_b <= rd_data;
      end else if (cmd.last) begin
        knot_a <= knot_a0;
        knot_b <= rd_data;
      end else begin
        knot_a <= rd_data;
      end
    end
    if (cmd.mul) begin
      span     <= span_s[POS_W-1:0];
      span_pos <= (span_s > 0);
      for (int c = 0; c < CH_COUNT; c++) num[c] <= num_next[c];
    end
    if (cmd.div_init) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        neg[c] <= num[c][NUM_W-1];
        sat[c] <= (num[c] >= $signed({3'd0, span_top}));
        rem[c] <= num[c][REM_W-1:0];
        quo[c] <= '0;
      end
    end
    if (cmd.div_step) begin
      for (int c = 0; c < CH_COUNT; c++) begin
        if (rem[c] >= trial) begin
          rem[c]              <= rem[c] - trial;
          quo[c][cmd.bit_idx] <= 1'b1;
        end
      end
    end
    if (cmd.out_load) begin
      color_word <= {ALPHA_OPAQUE, chan[0], chan[1], chan[2]};
    end
  end

endmodule

### rtl/gradient_colormap_interpolator_core.sv
// Piecewise-linear colormap: one palette index in, one opaque ARGB word out.
// Input channel in_valid/in_ready carries palette_index; the index sits at
// position index*257 on a 16-bit axis. Output channel out_valid/out_ready
// carries color_word (alpha 0xFF, red 23:16, green 15:8, blue 7:0).
// Knots are written through cfg_write/cfg_index/cfg_data, one 40-bit knot
// per write (position 39:24, then red, green, blue); write only while idle.
// One word is computed at a time. After acceptance the knot search examines
// knot pairs in order (1 to KNOT_COUNT-1 pairs), then follow a multiply
// step, a divider setup step and eight restoring-divider steps (one quotient
// bit each, three channels in parallel), then the output load. The next word
// is accepted once the controller has returned to idle after the output load.
// If the receiver stalls, the finished word holds in the output register and
// the block takes one more word, which waits before its output load until
// the held word is taken. Reset clears the controller, drops any output word,
// sets knot 0 to black at position 0 and all other knots to white at 0xFFFF.
module gradient_colormap_interpolator_core #(
  parameter int KNOT_COUNT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   palette_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gcmi_pkg::COLOR_W-1:0] color_word,
  input  logic                         cfg_write,
  input  logic [gcmi_pkg::KIDX_W-1:0]  cfg_index,
  input  logic [gcmi_pkg::KNOT_W-1:0]  cfg_data
);
  import gcmi_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [KIDX_W-1:0] rd_addr;
  logic [KNOT_W-1:0] rd_data;

  gcmi_knots u_knots (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  gcmi_ctrl #(
    .KNOT_COUNT (KNOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rd_addr   (rd_addr),
    .cmd       (cmd),
    .status    (status)
  );

  gcmi_dp u_dp (
    .clk           (clk),
    .palette_index (palette_index),
    .rd_data       (rd_data),
    .cmd           (cmd),
    .status        (status),
    .color_word    (color_word)
  );

endmodule

### bench/tb_gradient_colormap_interpolator_core.sv
module tb_gradient_colormap_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gcmi_pkg::*;

  localparam int KNOT_USED    = 8;
  localparam int DRAIN_CYCLES = KNOT_USED + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_PHASES  = 8;
  localparam int RAND_ITEMS   = 200;
  localparam int HOLD_CYCLES  = 500;

  typedef struct {
    logic [7:0]         idx;
    logic [COLOR_W-1:0] word;
  } color_slot_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         palette_index = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COLOR_W-1:0] color_word;
  logic               cfg_write = 1'b0;
  logic [KIDX_W-1:0]  cfg_index = '0;
  logic [KNOT_W-1:0]  cfg_data = '0;

  logic [KNOT_W-1:0]  knot_shadow [KNOT_SLOTS];
  logic [KNOT_W-1:0]  knot_stage [KNOT_SLOTS];
  logic [7:0]         index_backlog [$];
  color_slot_t        color_due [$];
  color_slot_t        due_slot;
  color_slot_t        new_slot;

  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 35;
  int results_seen = 0;
  int fail_count = 0;
  int settings_count = 0;
  int cycle_count = 0;

  gradient_colormap_interpolator_core #(
    .KNOT_COUNT(KNOT_USED)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .palette_index(palette_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .color_word   (color_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [COLOR_W-1:0] gradient_color(logic [7:0] idx);
    longint pos, pa, pb, ca, cb, v, span;
    int lo, hi, j, c, sh;
    logic found;
    logic [COLOR_W-1:0] word;
    pos = longint'(idx) * 257;
    lo = 0;
    hi = KNOT_USED - 1;
    found = 1'b0;
    for (j = 0; j + 1 < KNOT_USED; j++) begin
      if (!found && pos >= longint'(knot_shadow[j][39:24]) &&
          pos <= longint'(knot_shadow[j+1][39:24])) begin
        lo = j;
        hi = j + 1;
        found = 1'b1;
      end
    end
    pa = longint'(knot_shadow[lo][39:24]);
    pb = longint'(knot_shadow[hi][39:24]);
    word = '0;
    word[31:24] = ALPHA_OPAQUE;
    for (c = 0; c < CH_COUNT; c++) begin
      sh = 16 - 8 * c;
      ca = longint'(knot_shadow[lo][sh +: 8]);
      cb = longint'(knot_shadow[hi][sh +: 8]);
      if (pb > pa) begin
        span = pb - pa;
        v = (ca * span + (pos - pa) * (cb - ca)) / span;
      end else begin
        v = ca;
      end
      if (v < 0) v = 0;
      if (v > longint'(CH_MAX)) v = longint'(CH_MAX);
      word[sh +: 8] = v[7:0];
    end
    return word;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        index_backlog.delete(0);
        send_gap = pick_gap(send_idle_pct);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (index_backlog.size() > 0) begin
          in_valid <= 1'b1;
          palette_index <= index_backlog[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (color_due.size() == 0) begin
          $display("%0t: unexpected color_word expected none actual %08h", $time, color_word);
          fail_count++;
        end else begin
          due_slot = color_due.pop_front();
          if (color_word !== due_slot.word) begin
            $display("%0t: color_word mismatch for index %0d expected %08h actual %08h",
                     $time, due_slot.idx, due_slot.word, color_word);
            fail_count++;
          end
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 1100) hold_left = HOLD_CYCLES;
      end
      if (in_valid && in_ready) begin
        new_slot.idx  = palette_index;
        new_slot.word = gradient_color(palette_index);
        color_due = {color_due, new_slot};
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap(recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding",
               cycle_count, color_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic load_knots();
    int k;
    for (k = 0; k < KNOT_SLOTS; k++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= KIDX_W'(k);
      cfg_data  <= knot_stage[k];
      knot_shadow[k] = knot_stage[k];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  task automatic drain();
    while (index_backlog.size() != 0 || in_valid || color_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic make_layout(int mode);
    int p [KNOT_SLOTS];
    int k, m, tmp;
    for (k = 0; k < KNOT_SLOTS; k++) p[k] = $urandom_range(0, 65535);
    if (mode == 1 && $urandom_range(0, 1) == 0) p[3] = p[2];
    if (mode != 2) begin
      for (k = 0; k < KNOT_SLOTS - 1; k++) begin
        for (m = 0; m < KNOT_SLOTS - 1 - k; m++) begin
          if (p[m] > p[m+1]) begin
            tmp = p[m];
            p[m] = p[m+1];
            p[m+1] = tmp;
          end
        end
      end
    end
    if (mode == 0) begin
      p[0] = 0;
      p[KNOT_SLOTS-1] = 65535;
    end
    for (k = 0; k < KNOT_SLOTS; k++) begin
      knot_stage[k] = {16'(p[k]), 24'($urandom)};
      if ($urandom_range(0, 7) == 0) knot_stage[k][23:0] = '0;
      if ($urandom_range(0, 7) == 0) knot_stage[k][23:0] = '1;
    end
    if (mode == 3) begin
      m = $urandom_range(2, 6);
      for (k = m; k < KNOT_SLOTS; k++) knot_stage[k] = knot_stage[m-1];
    end
  endtask

  initial begin
    int r, n;
    knot_shadow[0] = KNOT_FIRST_RST;
    for (r = 1; r < KNOT_SLOTS; r++) knot_shadow[r] = KNOT_REST_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    settings_count = 1;

    index_backlog = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    drain();

    for (r = 0; r < KNOT_SLOTS; r++) knot_stage[r] = '0;
    load_knots();
    index_backlog = '{8'd0, 8'd77, 8'd255};
    drain();

    for (r = 0; r < KNOT_SLOTS; r++) knot_stage[r] = '1;
    load_knots();
    index_backlog = '{8'd0, 8'd255};
    drain();

    // extrapolate below and above the knot range, zero span in the middle
    knot_stage[0] = {16'h4000, 24'hC80A80};
    knot_stage[1] = {16'h6000, 24'h408020};
    knot_stage[2] = {16'h8000, 24'h00FF00};
    knot_stage[3] = {16'h8000, 24'hFF00FF};
    knot_stage[4] = {16'hA000, 24'h123456};
    knot_stage[5] = {16'hA000, 24'h123456};
    knot_stage[6] = {16'hA000, 24'h123456};
    knot_stage[7] = {16'hC000, 24'h0AFA00};
    load_knots();
    index_backlog = '{8'd0, 8'd32, 8'd64, 8'd96, 8'd128, 8'd160, 8'd200, 8'd255};
    drain();

    // unsorted knots
    knot_stage[0] = {16'hF000, 24'h10E0F0};
    knot_stage[1] = {16'h1000, 24'hFF0000};
    knot_stage[2] = {16'h9000, 24'h00FF00};
    knot_stage[3] = {16'h2000, 24'h0000FF};
    knot_stage[4] = {16'hFFFF, 24'h808080};
    knot_stage[5] = {16'h0000, 24'hFFFFFF};
    knot_stage[6] = {16'h7000, 24'h000000};
    knot_stage[7] = {16'h3000, 24'h55AA55};
    load_knots();
    index_backlog = '{8'd16, 8'd100, 8'd240};
    drain();

    for (r = 0; r < RAND_PHASES; r++) begin
      send_idle_pct = (r % 3 == 1 || r == 6) ? 0 : 35;
      recv_idle_pct = (r % 3 == 2 || r == 6) ? 0 : 35;
      make_layout(r % 4);
      load_knots();
      for (n = 0; n < RAND_ITEMS; n++) index_backlog = {index_backlog, 8'($urandom)};
      drain();
    end

    $display("checked %0d palette words across %0d knot settings", results_seen,
             settings_count);
    $display("included sorted, unsorted, repeated, zero-span and extrapolated knot layouts");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
